[rtl/core/assert_macros.svh]
// Assertion macros used by the parser unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/srap_pkg.sv]
// Types, constants and helpers for the STUN response address parser.
package srap_pkg;

  localparam logic [31:0] MAGIC_COOKIE     = 32'h2112a442;
  localparam logic [31:0] COOKIE_HIGH_MASK = 32'hffff0000;
  localparam logic [15:0] XOR_PORT         = 16'((MAGIC_COOKIE & COOKIE_HIGH_MASK) >> 16);
  localparam logic [15:0] ATTR_MAPPED      = 16'h0001;
  localparam logic [15:0] ATTR_XOR         = 16'h0020;
  localparam logic [15:0] ATTR_XOR_ALT     = 16'h8020;
  localparam logic [15:0] HEADER_BYTES     = 16'd20;
  localparam logic [15:0] POS_MAX          = 16'hffff;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_COOKIE = 2'd1;
  localparam logic [1:0] ST_TOO_LONG   = 2'd2;
  localparam logic [1:0] ST_SHORT      = 2'd3;

  localparam logic [1:0] FAM_NONE = 2'd0;
  localparam logic [7:0] FAM_IPV4 = 8'd1;
  localparam logic [7:0] FAM_IPV6 = 8'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  family;
    logic [15:0] mapped_port;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } result_t;

  // Address length in bytes for a family code, zero if unusable.
  function automatic logic [4:0] addr_bytes(input logic [7:0] fam);
    logic [4:0] n;
    n = 5'd0;
    if (fam == FAM_IPV4) n = 5'd4;
    else if (fam == FAM_IPV6) n = 5'd16;
    return n;
  endfunction

  // Expected cookie byte, index 0 is the most significant.
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = MAGIC_COOKIE[31:24];
      2'd1: b = MAGIC_COOKIE[23:16];
      2'd2: b = MAGIC_COOKIE[15:8];
      default: b = MAGIC_COOKIE[7:0];
    endcase
    return b;
  endfunction

endpackage

[rtl/core/srap_parser.sv]
// Per-byte header and attribute walker holding the parse state.
module srap_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output srap_pkg::result_t result
);

  logic [15:0]  pos_r, pos_nxt;
  logic [15:0]  mlen_r, mlen_nxt;
  logic         cookie_r, cookie_nxt;
  logic [95:0]  tid_r, tid_nxt;
  logic [15:0]  atype_r, atype_nxt;
  logic [15:0]  alen_r, alen_nxt;
  logic [15:0]  aoff_r, aoff_nxt;
  logic [1:0]   pstat_r, pstat_nxt;
  logic [7:0]   pfam_r, pfam_nxt;
  logic [15:0]  pport_r, pport_nxt;
  logic [127:0] paddr_r, paddr_nxt;
  logic [1:0]   ffam_r, ffam_nxt;
  logic [15:0]  fport_r, fport_nxt;
  logic [127:0] faddr_r, faddr_nxt;

  logic [15:0]  b;
  logic [15:0]  v;
  logic [16:0]  padded;
  logic [4:0]   cur_alen;
  logic         is_xor;
  logic [15:0]  xport;
  logic [127:0] xaddr;

  always_comb begin
    pos_nxt   = pos_r;
    mlen_nxt  = mlen_r;
    cookie_nxt = cookie_r;
    tid_nxt   = tid_r;
    atype_nxt = atype_r;
    alen_nxt  = alen_r;
    aoff_nxt  = aoff_r;
    pstat_nxt = pstat_r;
    pfam_nxt  = pfam_r;
    pport_nxt = pport_r;
    paddr_nxt = paddr_r;
    ffam_nxt  = ffam_r;
    fport_nxt = fport_r;
    faddr_nxt = faddr_r;
    b        = pos_r - srap_pkg::HEADER_BYTES;
    v        = aoff_r - 16'd4;
    padded   = ({1'b0, alen_r} + 17'd3) & ~17'd3;
    cur_alen = 5'd0;
    is_xor   = (atype_r == srap_pkg::ATTR_XOR) || (atype_r == srap_pkg::ATTR_XOR_ALT);
    xport    = 16'd0;
    xaddr    = 128'd0;

    if (step && pos_r != srap_pkg::POS_MAX) begin
      pos_nxt = pos_r + 16'd1;
      if (pos_r < srap_pkg::HEADER_BYTES) begin
        if (pos_r == 16'd2) begin
          mlen_nxt = {data_byte, 8'h00};
        end else if (pos_r == 16'd3) begin
          mlen_nxt = {mlen_r[15:8], data_byte};
        end else if (pos_r >= 16'd4 && pos_r <= 16'd7) begin
          if (srap_pkg::cookie_byte(pos_r[1:0]) != data_byte) cookie_nxt = 1'b0;
        end else if (pos_r >= 16'd8) begin
          tid_nxt = {tid_r[87:0], data_byte};
        end
      end else if (cookie_r && pstat_r == srap_pkg::ST_OK && b < mlen_r) begin
        if (aoff_r < 16'd4) begin
          case (aoff_r[1:0])
            2'd0: begin
              if ({1'b0, b} + 17'd4 <= {1'b0, mlen_r}) begin
                pfam_nxt  = 8'd0;
                pport_nxt = 16'd0;
                paddr_nxt = 128'd0;
                atype_nxt = {data_byte, 8'h00};
                aoff_nxt  = 16'd1;
              end
            end
            2'd1: begin
              atype_nxt = {atype_r[15:8], data_byte};
              aoff_nxt  = 16'd2;
            end
            2'd2: begin
              alen_nxt = {data_byte, 8'h00};
              aoff_nxt = 16'd3;
            end
            default: begin
              alen_nxt = {alen_r[15:8], data_byte};
              if ({2'b00, b} + 18'd1 + {2'b00, alen_nxt} > {2'b00, mlen_r}) begin
                pstat_nxt = srap_pkg::ST_TOO_LONG;
              end else if (alen_nxt == 16'd0) begin
                aoff_nxt = 16'd0;
              end else begin
                aoff_nxt = 16'd4;
              end
            end
          endcase
        end else begin
          if (v < alen_r) begin
            if (v == 16'd1) begin
              pfam_nxt = data_byte;
            end else if (v == 16'd2) begin
              pport_nxt = {data_byte, 8'h00};
            end else if (v == 16'd3) begin
              pport_nxt = {pport_r[15:8], data_byte};
            end else if (v >= 16'd4 &&
                         (v - 16'd4) < {11'd0, srap_pkg::addr_bytes(pfam_r)}) begin
              paddr_nxt = {paddr_r[119:0], data_byte};
            end
            // attribute value complete: validate and decode
            if ({1'b0, v} + 17'd1 == {1'b0, alen_r}) begin
              cur_alen = srap_pkg::addr_bytes(pfam_nxt);
              xport = pport_nxt;
              xaddr = paddr_nxt;
              if (is_xor) begin
                xport = pport_nxt ^ srap_pkg::XOR_PORT;
                if (pfam_nxt == srap_pkg::FAM_IPV4) begin
                  xaddr = paddr_nxt ^ {96'd0, srap_pkg::MAGIC_COOKIE};
                end else begin
                  xaddr = paddr_nxt ^ {srap_pkg::MAGIC_COOKIE, tid_r};
                end
              end
              if ((is_xor || atype_r == srap_pkg::ATTR_MAPPED) && cur_alen != 5'd0 &&
                  {1'b0, alen_r} >= 17'd4 + {12'd0, cur_alen}) begin
                ffam_nxt  = pfam_nxt[1:0];
                fport_nxt = xport;
                faddr_nxt = xaddr;
              end
            end
          end
          if ({1'b0, v} + 17'd1 >= padded) aoff_nxt = 16'd0;
          else aoff_nxt = aoff_r + 16'd1;
        end
      end
    end

    if (pos_nxt < srap_pkg::HEADER_BYTES || !cookie_nxt) begin
      result.status       = (pos_nxt < srap_pkg::HEADER_BYTES) ? srap_pkg::ST_SHORT
                                                               : srap_pkg::ST_BAD_COOKIE;
      result.family       = srap_pkg::FAM_NONE;
      result.mapped_port  = 16'd0;
      result.address_high = 64'd0;
      result.address_low  = 64'd0;
    end else begin
      result.status       = pstat_nxt;
      result.family       = ffam_nxt;
      result.mapped_port  = fport_nxt;
      result.address_high = faddr_nxt[127:64];
      result.address_low  = faddr_nxt[63:0];
    end
  end

  // the final byte of a datagram returns everything to the reset state
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      pos_r    <= 16'd0;
      mlen_r   <= 16'd0;
      cookie_r <= 1'b1;
      tid_r    <= 96'd0;
      atype_r  <= 16'd0;
      alen_r   <= 16'd0;
      aoff_r   <= 16'd0;
      pstat_r  <= srap_pkg::ST_OK;
      pfam_r   <= 8'd0;
      pport_r  <= 16'd0;
      paddr_r  <= 128'd0;
      ffam_r   <= srap_pkg::FAM_NONE;
      fport_r  <= 16'd0;
      faddr_r  <= 128'd0;
    end else begin
      pos_r    <= pos_nxt;
      mlen_r   <= mlen_nxt;
      cookie_r <= cookie_nxt;
      tid_r    <= tid_nxt;
      atype_r  <= atype_nxt;
      alen_r   <= alen_nxt;
      aoff_r   <= aoff_nxt;
      pstat_r  <= pstat_nxt;
      pfam_r   <= pfam_nxt;
      pport_r  <= pport_nxt;
      paddr_r  <= paddr_nxt;
      ffam_r   <= ffam_nxt;
      fport_r  <= fport_nxt;
      faddr_r  <= faddr_nxt;
    end
  end

endmodule

[rtl/core/stun_response_address_parser_unit.sv]
// The final byte of a datagram passes the input register, then its result is registered with out_valid set.
// Throughput: one byte item per cycle; only a stalled, full result register holds input.
// The input register feeds the byte walker, whose next state also forms the result.
// Reset (rst_n low, synchronous) empties both registers and clears the parse state.
// Each final byte also returns the parse state to its reset values.
`include "assert_macros.svh"

module stun_response_address_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [1:0]  out_family,
  output logic [15:0] out_mapped_port,
  output logic [63:0] out_address_high,
  output logic [63:0] out_address_low
);

  logic              in_valid_r;
  logic [7:0]        in_data_r;
  logic              in_last_r;
  logic              out_valid_r;
  srap_pkg::result_t res_r;
  srap_pkg::result_t res;
  logic              advance;
  logic              step;

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;
  assign step     = advance && in_valid_r;

  srap_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_r),
    .last_byte (in_last_r),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      in_valid_r  <= in_valid;
      out_valid_r <= in_valid_r && in_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
    if (step && in_last_r) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_family       = res_r.family;
  assign out_mapped_port  = res_r.mapped_port;
  assign out_address_high = res_r.address_high;
  assign out_address_low  = res_r.address_low;

  `ASSERT_NXT(a_last_gives_result, clk, rst_n, step && in_last_r, out_valid_r)
  `ASSERT_NXT(a_mid_byte_no_result, clk, rst_n, step && !in_last_r, !out_valid_r)
  `ASSERT_IMP(a_full_blocks_input, clk, rst_n, out_valid_r && out_stall, in_stall)
  `ASSERT_IMP(a_error_no_address, clk, rst_n,
              out_valid_r && (out_status == srap_pkg::ST_SHORT ||
                              out_status == srap_pkg::ST_BAD_COOKIE),
              out_family == srap_pkg::FAM_NONE)

endmodule
